### src/itc_pkg.sv
`timescale 1ns / 1ps

package itc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int NUM_CHAN   = 4;
  localparam int CHAN_W     = 8;
  localparam int TOL_W      = 8;
  localparam int DELTA_W    = CHAN_W + 1;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int COUNT_W    = 25;
  localparam int BUDGET_W   = 17;
  localparam int Q16_SHIFT  = 16;
  localparam int PROD_W     = BUDGET_W + COUNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REND_WIDTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REND_HEIGHT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REF_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_REF_HEIGHT = CFG_IDX_W'(5);

  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    logic                              fails;
    logic                              last;
    logic [COORD_W-1:0]                x;
    logic [COORD_W-1:0]                y;
    delta_t [NUM_CHAN-1:0]             delta;
  } q_entry_t;

  typedef struct packed {
    logic [TOL_W-1:0] tolerance;
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
  } front_cfg_t;

  typedef struct packed {
    logic               mismatch;
    logic [COUNT_W-1:0] total;
    logic [PROD_W-1:0]  limit;
  } back_cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### src/itc_pix_if.sv
`timescale 1ns / 1ps

interface itc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [itc_pkg::CHAN_W-1:0] rendered_red;
  logic [itc_pkg::CHAN_W-1:0] rendered_green;
  logic [itc_pkg::CHAN_W-1:0] rendered_blue;
  logic [itc_pkg::CHAN_W-1:0] rendered_alpha;
  logic [itc_pkg::CHAN_W-1:0] expected_red;
  logic [itc_pkg::CHAN_W-1:0] expected_green;
  logic [itc_pkg::CHAN_W-1:0] expected_blue;
  logic [itc_pkg::CHAN_W-1:0] expected_alpha;

  modport source(output valid, rendered_red, rendered_green, rendered_blue, rendered_alpha,
                 expected_red, expected_green, expected_blue, expected_alpha,
                 input ready);
  modport sink(input valid, rendered_red, rendered_green, rendered_blue, rendered_alpha,
               expected_red, expected_green, expected_blue, expected_alpha,
               output ready);
endinterface

### src/itc_res_if.sv
`timescale 1ns / 1ps

interface itc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        passed;
  logic                        size_mismatch;
  logic [itc_pkg::COUNT_W-1:0] failing_count;
  logic [itc_pkg::COUNT_W-1:0] total_count;
  logic                        mismatch_found;
  logic [itc_pkg::COORD_W-1:0] first_x;
  logic [itc_pkg::COORD_W-1:0] first_y;
  logic signed [itc_pkg::DELTA_W-1:0] delta_red;
  logic signed [itc_pkg::DELTA_W-1:0] delta_green;
  logic signed [itc_pkg::DELTA_W-1:0] delta_blue;
  logic signed [itc_pkg::DELTA_W-1:0] delta_alpha;

  modport source(output valid, passed, size_mismatch, failing_count, total_count,
                 mismatch_found, first_x, first_y, delta_red, delta_green, delta_blue,
                 delta_alpha, input ready);
  modport sink(input valid, passed, size_mismatch, failing_count, total_count,
               mismatch_found, first_x, first_y, delta_red, delta_green, delta_blue,
               delta_alpha, output ready);
endinterface

### src/itc_cfg_if.sv
`timescale 1ns / 1ps

interface itc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [itc_pkg::CFG_IDX_W-1:0]  index;
  logic [itc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/itc_front.sv
`timescale 1ns / 1ps

module itc_front (
  input  logic                clk,
  input  logic                rst,
  itc_pix_if.sink             pix,
  input  itc_pkg::front_cfg_t fcfg,
  output logic                push_valid,
  input  logic                push_ready,
  output itc_pkg::q_entry_t   push_entry
);
  import itc_pkg::*;

  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  rend [NUM_CHAN];
  logic [CHAN_W-1:0]  expd [NUM_CHAN];
  delta_t             d    [NUM_CHAN];
  logic [CHAN_W-1:0]  mag  [NUM_CHAN];
  logic               fails;
  logic               col_wrap;
  logic               row_wrap;
  logic               accept;

  assign rend[0] = pix.rendered_red;
  assign rend[1] = pix.rendered_green;
  assign rend[2] = pix.rendered_blue;
  assign rend[3] = pix.rendered_alpha;
  assign expd[0] = pix.expected_red;
  assign expd[1] = pix.expected_green;
  assign expd[2] = pix.expected_blue;
  assign expd[3] = pix.expected_alpha;

  always_comb begin
    fails = 1'b0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      d[c]   = $signed({1'b0, rend[c]}) - $signed({1'b0, expd[c]});
      mag[c] = d[c][DELTA_W-1] ? CHAN_W'(-d[c]) : CHAN_W'(d[c]);
      if (mag[c] > fcfg.tolerance) fails = 1'b1;
    end
  end

  assign col_wrap = (DIM_W'(column) + DIM_W'(1)) >= fcfg.fw;
  assign row_wrap = (DIM_W'(row) + DIM_W'(1)) >= fcfg.fh;

  assign pix.ready  = push_ready;
  assign push_valid = pix.valid;
  assign accept     = pix.valid && push_ready;

  always_comb begin
    push_entry.fails = fails;
    push_entry.last  = col_wrap && row_wrap;
    push_entry.x     = column;
    push_entry.y     = row;
    for (int c = 0; c < NUM_CHAN; c++) begin
      push_entry.delta[c] = d[c];
    end
  end

  // advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column <= '0;
        row    <= row_wrap ? '0 : row + COORD_W'(1);
      end else begin
        column <= column + COORD_W'(1);
      end
    end
  end

endmodule

### src/itc_queue.sv
`timescale 1ns / 1ps

module itc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  itc_pkg::q_entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output itc_pkg::q_entry_t pop_entry
);
  import itc_pkg::*;

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

### src/itc_back.sv
`timescale 1ns / 1ps

module itc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  itc_pkg::q_entry_t  pop_entry,
  input  itc_pkg::back_cfg_t bcfg,
  itc_res_if.source          res
);
  import itc_pkg::*;

  logic [COUNT_W-1:0]    tally;
  logic                  found;
  logic [COORD_W-1:0]    cap_x;
  logic [COORD_W-1:0]    cap_y;
  delta_t [NUM_CHAN-1:0] cap_delta;

  logic [COUNT_W-1:0]    tally_next;
  logic                  found_next;
  logic [COORD_W-1:0]    cap_x_next;
  logic [COORD_W-1:0]    cap_y_next;
  delta_t [NUM_CHAN-1:0] cap_delta_next;

  logic                  fin_valid;
  logic [COUNT_W-1:0]    fin_tally;
  logic                  fin_found;
  logic [COORD_W-1:0]    fin_x;
  logic [COORD_W-1:0]    fin_y;
  delta_t [NUM_CHAN-1:0] fin_delta;

  logic                  fin_adv;
  logic                  pop;
  logic                  show;

  assign fin_adv   = fin_valid && (!res.valid || res.ready);
  assign pop_ready = !fin_valid || fin_adv;
  assign pop       = pop_valid && pop_ready;
  assign show      = !bcfg.mismatch && fin_found;

  always_comb begin
    tally_next     = tally;
    found_next     = found;
    cap_x_next     = cap_x;
    cap_y_next     = cap_y;
    cap_delta_next = cap_delta;
    if (pop_entry.fails) begin
      if (tally != '1) tally_next = tally + COUNT_W'(1);
      if (!found) begin
        found_next     = 1'b1;
        cap_x_next     = pop_entry.x;
        cap_y_next     = pop_entry.y;
        cap_delta_next = pop_entry.delta;
      end
    end
  end

  // accumulate the frame, hand it to the verdict stage on its last item
  always_ff @(posedge clk) begin
    if (rst) begin
      tally     <= '0;
      found     <= 1'b0;
      fin_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (pop_entry.last) begin
          tally <= '0;
          found <= 1'b0;
        end else begin
          tally <= tally_next;
          found <= found_next;
        end
      end
      if (pop && pop_entry.last) fin_valid <= 1'b1;
      else if (fin_adv) fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cap_x     <= cap_x_next;
      cap_y     <= cap_y_next;
      cap_delta <= cap_delta_next;
    end
    if (pop && pop_entry.last) begin
      fin_tally <= tally_next;
      fin_found <= found_next;
      fin_x     <= cap_x_next;
      fin_y     <= cap_y_next;
      fin_delta <= cap_delta_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (fin_adv) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      res.passed         <= !bcfg.mismatch &&
                            ((PROD_W'(fin_tally) << Q16_SHIFT) < bcfg.limit);
      res.size_mismatch  <= bcfg.mismatch;
      res.failing_count  <= bcfg.mismatch ? bcfg.total : fin_tally;
      res.total_count    <= bcfg.total;
      res.mismatch_found <= show;
      res.first_x        <= show ? fin_x : '0;
      res.first_y        <= show ? fin_y : '0;
      res.delta_red      <= show ? fin_delta[0] : '0;
      res.delta_green    <= show ? fin_delta[1] : '0;
      res.delta_blue     <= show ? fin_delta[2] : '0;
      res.delta_alpha    <= show ? fin_delta[3] : '0;
    end
  end

endmodule

### src/image_tolerance_comparator_core.sv
`timescale 1ns / 1ps
// Golden-image compare with per-channel tolerance.
// pix: one rendered/reference RGBA8 pixel pair per item, raster order over the
//   reference frame. res: one verdict item after the last pixel of each frame.
// cfg: register writes (index, data), always ready; write only while idle.
// Throughput: one pixel per cycle while res takes its verdicts; frames may
//   follow each other with no gap. The frame's last item passes the two-entry
//   queue into the verdict stage, whose result the output register then shows
//   on res; the front stage is combinational. The pass limit (budget times
//   pixel count) is rebuilt in two registered multiply steps.
// Reset clears the raster position, the failure tally, the first-failure
//   capture flag and all queued items; registers return to tolerance 0, budget 0,
//   all dimensions 1.
// When res stalls, the verdict stage and queue fill and pix.ready drops;
//   the output register holds its item until taken.
module image_tolerance_comparator_core (
  input  logic   clk,
  input  logic   rst,
  itc_pix_if.sink   pix,
  itc_res_if.source res,
  itc_cfg_if.sink   cfg
);
  import itc_pkg::*;

  logic [TOL_W-1:0]    tolerance;
  logic [BUDGET_W-1:0] budget;
  logic [DIM_W-1:0]    rend_width;
  logic [DIM_W-1:0]    rend_height;
  logic [DIM_W-1:0]    ref_width;
  logic [DIM_W-1:0]    ref_height;

  logic [DIM_W-1:0]    rw_c;
  logic [DIM_W-1:0]    rh_c;
  logic [DIM_W-1:0]    fw_c;
  logic [DIM_W-1:0]    fh_c;

  logic                mismatch;
  logic [COUNT_W-1:0]  total;
  logic [PROD_W-1:0]   limit;

  front_cfg_t          fcfg;
  back_cfg_t           bcfg;

  logic                push_valid;
  logic                push_ready;
  q_entry_t            push_entry;
  logic                pop_valid;
  logic                pop_ready;
  q_entry_t            pop_entry;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= '0;
      budget      <= '0;
      rend_width  <= DIM_W'(1);
      rend_height <= DIM_W'(1);
      ref_width   <= DIM_W'(1);
      ref_height  <= DIM_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TOLERANCE:   tolerance   <= cfg.data[TOL_W-1:0];
        REG_BUDGET:      budget      <= cfg.data[BUDGET_W-1:0];
        REG_REND_WIDTH:  rend_width  <= cfg.data[DIM_W-1:0];
        REG_REND_HEIGHT: rend_height <= cfg.data[DIM_W-1:0];
        REG_REF_WIDTH:   ref_width   <= cfg.data[DIM_W-1:0];
        REG_REF_HEIGHT:  ref_height  <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign rw_c = clamp_dim(rend_width,  DIM_W'(MAX_WIDTH));
  assign rh_c = clamp_dim(rend_height, DIM_W'(MAX_HEIGHT));
  assign fw_c = clamp_dim(ref_width,   DIM_W'(MAX_WIDTH));
  assign fh_c = clamp_dim(ref_height,  DIM_W'(MAX_HEIGHT));

  // size-mismatch flag and pixel count, then the pass limit from the registered count in the next cycle
  always_ff @(posedge clk) begin
    mismatch <= (rw_c != fw_c) || (rh_c != fh_c);
    total    <= COUNT_W'(fw_c) * COUNT_W'(fh_c);
    limit    <= PROD_W'(budget) * PROD_W'(total);
  end

  assign fcfg.tolerance = tolerance;
  assign fcfg.fw        = fw_c;
  assign fcfg.fh        = fh_c;
  assign bcfg.mismatch  = mismatch;
  assign bcfg.total     = total;
  assign bcfg.limit     = limit;

  itc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .fcfg       (fcfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  itc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  itc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .bcfg      (bcfg),
    .res       (res)
  );

`ifndef NO_ASSERTIONS
  a_mismatch_verdict: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.size_mismatch |->
      !res.passed && !res.mismatch_found && (res.failing_count == res.total_count))
    else $error("size mismatch verdict inconsistent");

  a_no_capture_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.mismatch_found |->
      (res.first_x == '0) && (res.first_y == '0) && (res.delta_red == '0) &&
      (res.delta_green == '0) && (res.delta_blue == '0) && (res.delta_alpha == '0))
    else $error("capture fields set without a captured failure");

  a_capture_counted: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.mismatch_found |-> (res.failing_count != '0))
    else $error("captured failure with zero failing count");

  a_verdict_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(pop_valid, 2) || $past(pop_valid, 3) ||
      $past(push_valid, 3))
    else $error("verdict without a preceding item");
`endif

endmodule
